// ===== rtl/cover_art_locator_macros.svh =====
// Assertion macros for the checker file of the cover art locator.
// Depends on nothing; include by bare file name.
`ifndef COVER_ART_LOCATOR_MACROS_SVH
`define COVER_ART_LOCATOR_MACROS_SVH

// Same-cycle implication, gated off while reset is high.
`define CAL_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, gated off while reset is high.
`define CAL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/cal_pkg.sv =====
// Shared types and constants of the cover art locator.
// Depends on nothing; used by the walkers, the top level and the checker.
package cal_pkg;

   localparam int unsigned CAL_SCAN_LIMIT_DEFAULT = 262144;

   localparam logic [31:0] TAG_APIC = 32'h41504943;
   localparam logic [31:0] TAG_COVR = 32'h636F7672;
   localparam logic [31:0] TAG_FLAC = 32'h664C6143;
   localparam logic [31:0] TAG_FTYP = 32'h66747970;
   localparam logic [31:0] TAG_PICT = 32'h50494354;
   localparam logic [23:0] TAG_ID3  = 24'h494433;

   localparam logic [6:0]  FLAC_PICTURE_TYPE = 7'd6;
   localparam logic [32:0] ID3_HDR_LEN       = 33'd10;
   localparam logic [32:0] ID3_FIRST_FRAME   = 33'd10;
   localparam logic [32:0] FLAC_FIRST_BLOCK  = 33'd4;

   typedef enum logic [1:0] {
      CONT_NONE = 2'd0,
      CONT_ID3  = 2'd1,
      CONT_FLAC = 2'd2,
      CONT_MP4  = 2'd3
   } container_type;

   typedef enum logic [2:0] {
      WALK_GO    = 3'b001,
      WALK_FOUND = 3'b010,
      WALK_STOP  = 3'b100
   } walk_state_type;

   // What every walker sees of the byte being taken.
   typedef struct packed {
      logic          advance;  // an item is taken this cycle
      logic          clear;    // the item is the last of its file
      logic [31:0]   pos;
      logic [63:0]   recent;   // newest byte in the low byte
      logic [31:0]   limit;
      logic [31:0]   len;
      container_type kind;     // container after this byte
   } step_type;

   // A walker's verdict after this byte.
   typedef struct packed {
      logic        found;
      logic [31:0] offset;
      logic [31:0] size;
   } hit_type;

endpackage

// ===== rtl/cal_if.sv =====
// Valid/ready channel interfaces for the byte stream and the result.
// Depends on nothing.
interface cal_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  data_byte;
   logic        last_byte;
   logic [31:0] file_length;

   modport source(output valid, data_byte, last_byte, file_length, input ready);
   modport sink(input valid, data_byte, last_byte, file_length, output ready);
endinterface

interface cal_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [1:0]  container;
   logic [31:0] image_offset;
   logic [31:0] image_size;

   modport source(output valid, found, container, image_offset, image_size, input ready);
   modport sink(input valid, found, container, image_offset, image_size, output ready);
endinterface

// ===== rtl/cal_id3_walker.sv =====
// ID3v2 frame walker: follows 10-byte frame headers and stops at APIC.
// Depends on cal_pkg.
module cal_id3_walker
   import cal_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  step_type step,
   output hit_type  hit
);

   logic [32:0]    start_ff, start_in, start_upd;
   walk_state_type state_ff, state_in, state_upd;
   logic [31:0]    off_ff, off_in, off_upd;
   logic [31:0]    size_ff, size_in, size_upd;

   logic [32:0] hdr_pos;
   logic [33:0] hdr_end;
   logic [28:0] frame_size;
   logic [32:0] frame_end;
   logic        at_header;

   assign hdr_pos    = start_ff + 33'd7;
   assign hdr_end    = {1'b0, start_ff} + {1'b0, ID3_HDR_LEN};
   // size bytes are ORed as they stand, not masked to seven bits
   assign frame_size = {step.recent[31:24], 21'd0}
                     | {7'd0, step.recent[23:16], 14'd0}
                     | {14'd0, step.recent[15:8], 7'd0}
                     | {21'd0, step.recent[7:0]};
   assign frame_end  = hdr_end[32:0] + {4'd0, frame_size};
   assign at_header  = step.advance && (step.kind == CONT_ID3) && (state_ff == WALK_GO)
                     && ({1'b0, step.pos} == hdr_pos);

   always_comb begin
      start_upd = start_ff;
      state_upd = state_ff;
      off_upd   = off_ff;
      size_upd  = size_ff;
      if (at_header) begin
         if (hdr_end >= {2'd0, step.limit}) begin
            state_upd = WALK_STOP;
         end else if (frame_size == '0 || frame_end > {1'b0, step.limit}) begin
            state_upd = WALK_STOP;
         end else if (step.recent[63:32] == TAG_APIC) begin
            state_upd = WALK_FOUND;
            off_upd   = hdr_end[31:0];
            size_upd  = {3'd0, frame_size};
         end else begin
            start_upd = frame_end;
         end
      end
   end

   assign start_in = step.clear ? ID3_FIRST_FRAME : start_upd;
   assign state_in = step.clear ? WALK_GO : state_upd;
   assign off_in   = off_upd;
   assign size_in  = size_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= ID3_FIRST_FRAME;
         state_ff <= WALK_GO;
      end else begin
         start_ff <= start_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff  <= off_in;
      size_ff <= size_in;
   end

   assign hit.found  = (state_upd == WALK_FOUND);
   assign hit.offset = off_upd;
   assign hit.size   = size_upd;

endmodule

// ===== rtl/cal_flac_walker.sv =====
// FLAC metadata block walker: follows block headers up to the last-block flag.
// Depends on cal_pkg.
module cal_flac_walker
   import cal_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  step_type step,
   output hit_type  hit
);

   logic [32:0]    start_ff, start_in, start_upd;
   walk_state_type state_ff, state_in, state_upd;
   logic [31:0]    off_ff, off_in, off_upd;
   logic [31:0]    size_ff, size_in, size_upd;

   logic [32:0] hdr_pos;
   logic [33:0] data_wide;
   logic [33:0] blk_end;
   logic [7:0]  header;
   logic [23:0] blk_size;
   logic        at_header;

   assign header    = step.recent[31:24];
   assign blk_size  = step.recent[23:0];
   assign hdr_pos   = start_ff + 33'd3;
   assign data_wide = {1'b0, start_ff} + 34'd4;
   assign blk_end   = {1'b0, data_wide[32:0]} + {10'd0, blk_size};
   assign at_header = step.advance && (step.kind == CONT_FLAC) && (state_ff == WALK_GO)
                    && ({1'b0, step.pos} == hdr_pos);

   always_comb begin
      start_upd = start_ff;
      state_upd = state_ff;
      off_upd   = off_ff;
      size_upd  = size_ff;
      if (at_header) begin
         if (data_wide >= {2'd0, step.limit}) begin
            state_upd = WALK_STOP;
         end else if (blk_end > {2'd0, step.len}) begin
            // block runs past the file itself
            state_upd = WALK_STOP;
         end else if (header[6:0] == FLAC_PICTURE_TYPE) begin
            state_upd = WALK_FOUND;
            off_upd   = data_wide[31:0];
            size_upd  = {8'd0, blk_size};
         end else begin
            start_upd = blk_end[32:0];
            if (header[7]) begin
               state_upd = WALK_STOP;
            end
         end
      end
   end

   assign start_in = step.clear ? FLAC_FIRST_BLOCK : start_upd;
   assign state_in = step.clear ? WALK_GO : state_upd;
   assign off_in   = off_upd;
   assign size_in  = size_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= FLAC_FIRST_BLOCK;
         state_ff <= WALK_GO;
      end else begin
         start_ff <= start_in;
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff  <= off_in;
      size_ff <= size_in;
   end

   assign hit.found  = (state_upd == WALK_FOUND);
   assign hit.offset = off_upd;
   assign hit.size   = size_upd;

endmodule

// ===== rtl/cal_mp4_scanner.sv =====
// MP4 scanner: after an ftyp brand, checks every 4-aligned box for covr.
// Depends on cal_pkg.
module cal_mp4_scanner
   import cal_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  step_type step,
   output hit_type  hit
);

   logic        ftyp_ff, ftyp_in, ftyp_upd;
   logic        hit_ff, hit_in, hit_upd;
   logic [31:0] off_ff, off_in, off_upd;
   logic [31:0] size_ff, size_in, size_upd;

   logic [32:0] next_pos;
   logic [31:0] box_start;
   logic [32:0] box_end;
   logic [31:0] box_size;
   logic        at_box;

   assign box_size  = step.recent[63:32];
   assign next_pos  = {1'b0, step.pos} + 33'd1;
   assign box_start = step.pos - 32'd7;
   assign box_end   = {1'b0, box_start} + {1'b0, box_size};

   assign ftyp_upd = ftyp_ff
                   || (step.advance && step.pos == 32'd7 && step.recent[31:0] == TAG_FTYP);
   assign at_box   = step.advance && ftyp_upd && !hit_ff && (step.pos >= 32'd7)
                   && (step.pos[1:0] == 2'd3);

   always_comb begin
      hit_upd  = hit_ff;
      off_upd  = off_ff;
      size_upd = size_ff;
      // an oversized covr is skipped and the scan goes on
      if (at_box && next_pos < {1'b0, step.limit} && step.recent[31:0] == TAG_COVR
          && box_end <= {1'b0, step.len}) begin
         hit_upd  = 1'b1;
         off_upd  = next_pos[31:0];
         size_upd = box_size - 32'd8;
      end
   end

   assign ftyp_in = step.clear ? 1'b0 : ftyp_upd;
   assign hit_in  = step.clear ? 1'b0 : hit_upd;
   assign off_in  = off_upd;
   assign size_in = size_upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         ftyp_ff <= 1'b0;
         hit_ff  <= 1'b0;
      end else begin
         ftyp_ff <= ftyp_in;
         hit_ff  <= hit_in;
      end
   end

   always_ff @(posedge clock) begin
      off_ff  <= off_in;
      size_ff <= size_in;
   end

   assign hit.found  = hit_upd;
   assign hit.offset = off_upd;
   assign hit.size   = size_upd;

endmodule

// ===== rtl/cover_art_locator.sv =====
// Top level of the cover art locator: byte tracking, walkers and result register.
// Depends on cal_pkg, cal_if, cal_id3_walker, cal_flac_walker and cal_mp4_scanner.
//
// The block takes an audio file one byte per item, from offset zero, together
// with the file length, and reports where embedded cover art sits. Three walkers
// watch the first min(file_length, SCAN_LIMIT) bytes at once: ID3v2 frames up to
// the first APIC frame, FLAC metadata blocks up to the last-block flag (a
// picture block counts only if "PICT" shows up in the window), and 4-aligned
// MP4 "covr" boxes once "ftyp" sits at bytes 4 to 7. The item flagged as the
// last byte produces exactly one result, chosen ID3 first, then FLAC, then MP4,
// or found = 0 with every field zero; the block then starts afresh for the next
// file. A stream runs at one byte per clock; the result appears in the output
// register in the cycle after the last byte is taken. The input stalls only
// while a result sits unclaimed and the sink holds ready low. The longest path
// is a walker's 33-bit header add and limit compare, done in the cycle the item
// is taken.
module cover_art_locator
   import cal_pkg::*;
#(
   parameter int unsigned SCAN_LIMIT = CAL_SCAN_LIMIT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   cal_req_if.sink     req_ch,
   cal_rsp_if.source   rsp_ch
);

   localparam logic [31:0] SCAN_LIMIT_W = 32'(SCAN_LIMIT);

   // byte tracking
   logic [31:0]   count_ff, count_in, count_upd;
   logic [63:0]   recent_ff, recent_in, recent_upd;
   container_type kind_ff, kind_in, kind_upd;
   logic          pict_ff, pict_in, pict_upd;

   // result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic          found_ff, found_in;
   container_type cont_ff, cont_in;
   logic [31:0]   offset_ff, offset_in;
   logic [31:0]   size_ff, size_in;

   logic     take;
   logic     take_last;
   logic     load_rsp;
   logic [31:0] limit;
   step_type step;
   hit_type  id3_hit;
   hit_type  flac_hit;
   hit_type  mp4_hit;

   // Take a new item whenever the result register is free or being drained.
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign take         = req_ch.valid && req_ch.ready;
   assign take_last    = take && req_ch.last_byte;

   assign limit = (req_ch.file_length < SCAN_LIMIT_W) ? req_ch.file_length : SCAN_LIMIT_W;
   assign recent_upd = {recent_ff[55:0], req_ch.data_byte};

   // Magic numbers sit at fixed offsets; FLAC is checked after ID3.
   always_comb begin
      kind_upd = kind_ff;
      if (count_ff == 32'd2 && recent_upd[23:0] == TAG_ID3) begin
         kind_upd = CONT_ID3;
      end
      if (count_ff == 32'd3 && recent_upd[31:0] == TAG_FLAC) begin
         kind_upd = CONT_FLAC;
      end
   end

   assign pict_upd = pict_ff || (count_ff >= 32'd3 && count_ff < limit
                                 && recent_upd[31:0] == TAG_PICT);

   // Saturate the byte count: offsets that far out lie beyond every window.
   assign count_upd = (count_ff == '1) ? count_ff : count_ff + 32'd1;

   assign step.advance = take;
   assign step.clear   = take_last;
   assign step.pos     = count_ff;
   assign step.recent  = recent_upd;
   assign step.limit   = limit;
   assign step.len     = req_ch.file_length;
   assign step.kind    = kind_upd;

   cal_id3_walker u_id3 (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .hit   (id3_hit)
   );

   cal_flac_walker u_flac (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .hit   (flac_hit)
   );

   cal_mp4_scanner u_mp4 (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .hit   (mp4_hit)
   );

   // Advance the tracking state on every item; drop it all after the last one.
   always_comb begin
      count_in  = count_ff;
      recent_in = recent_ff;
      kind_in   = kind_ff;
      pict_in   = pict_ff;
      if (take_last) begin
         count_in  = '0;
         recent_in = '0;
         kind_in   = CONT_NONE;
         pict_in   = 1'b0;
      end else if (take) begin
         count_in  = count_upd;
         recent_in = recent_upd;
         kind_in   = kind_upd;
         pict_in   = pict_upd;
      end
   end

   // Pick the result by priority: ID3, then FLAC with a PICT seen, then MP4.
   always_comb begin
      found_in  = 1'b0;
      cont_in   = CONT_NONE;
      offset_in = '0;
      size_in   = '0;
      priority if (kind_upd == CONT_ID3 && id3_hit.found) begin
         found_in  = 1'b1;
         cont_in   = CONT_ID3;
         offset_in = id3_hit.offset;
         size_in   = id3_hit.size;
      end else if (kind_upd == CONT_FLAC && flac_hit.found && pict_upd) begin
         found_in  = 1'b1;
         cont_in   = CONT_FLAC;
         offset_in = flac_hit.offset;
         size_in   = flac_hit.size;
      end else if (mp4_hit.found) begin
         found_in  = 1'b1;
         cont_in   = CONT_MP4;
         offset_in = mp4_hit.offset;
         size_in   = mp4_hit.size;
      end else begin
         found_in  = 1'b0;
      end
   end

   // Hold the result until the sink takes it.
   assign load_rsp     = take_last;
   assign rsp_valid_in = load_rsp || (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         recent_ff    <= '0;
         kind_ff      <= CONT_NONE;
         pict_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         recent_ff    <= recent_in;
         kind_ff      <= kind_in;
         pict_ff      <= pict_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         found_ff  <= found_in;
         cont_ff   <= cont_in;
         offset_ff <= offset_in;
         size_ff   <= size_in;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.found        = found_ff;
   assign rsp_ch.container    = cont_ff;
   assign rsp_ch.image_offset = offset_ff;
   assign rsp_ch.image_size   = size_ff;

endmodule

// ===== rtl/cal_checker.sv =====
// Port-level checker for the cover art locator, bound to its top level.
// Depends on cal_pkg, cover_art_locator_macros.svh and cover_art_locator.
`include "cover_art_locator_macros.svh"

module cal_checker
   import cal_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_found,
   input logic [1:0]  rsp_container,
   input logic [31:0] rsp_image_offset,
   input logic [31:0] rsp_image_size
);

   logic took_last;

   assign took_last = req_valid && req_ready && req_last_byte;

   // found and a container code go together
   `CAL_ASSERT_HOLDS(a_found_matches_container, clock, reset, rsp_valid, (rsp_found == (rsp_container != CONT_NONE)), "found disagrees with container")

   // an empty result carries no position
   `CAL_ASSERT_HOLDS(a_empty_is_zero, clock, reset, rsp_valid && !rsp_found, (rsp_image_offset == '0 && rsp_image_size == '0), "empty result carries data")

   // FLAC block sizes are 24 bits, ID3 frame sizes 29 bits
   `CAL_ASSERT_HOLDS(a_size_range, clock, reset, rsp_valid, ((rsp_container != CONT_FLAC || rsp_image_size[31:24] == '0) && (rsp_container != CONT_ID3 || rsp_image_size[31:29] == '0)), "image size out of range")

   // a result only follows the last byte of a file
   `CAL_ASSERT_NEXT(a_no_stray_result, clock, reset, !rsp_valid && !took_last, !rsp_valid, "result without a last byte")

   // a stalled result holds
   `CAL_ASSERT_NEXT(a_result_holds, clock, reset, rsp_valid && !rsp_ready, (rsp_valid && $stable(rsp_found) && $stable(rsp_container) && $stable(rsp_image_offset) && $stable(rsp_image_size)), "stalled result changed")

endmodule

bind cover_art_locator cal_checker u_cal_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_last_byte    (req_ch.last_byte),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_found        (rsp_ch.found),
   .rsp_container    (rsp_ch.container),
   .rsp_image_offset (rsp_ch.image_offset),
   .rsp_image_size   (rsp_ch.image_size)
);

// ===== verif/cover_art_locator_tb.sv =====
// Self-checking bench for the cover art locator: streams whole files one byte per item
// and compares each per-file result against an in-bench model of the three walkers or a hand-typed verdict.
// Depends on cal_pkg, cal_if and cover_art_locator from the RTL.
module cover_art_locator_tb;
   import cal_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned SCAN_WINDOW = CAL_SCAN_LIMIT_DEFAULT;
   localparam logic [63:0] MASK33      = 64'h1_FFFF_FFFF;
   localparam int          RANDOM_BYTES = 620;
   localparam int          MIN_FILES    = 12;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          DRAIN_CYCLES = 8;
   localparam int          NUM_CASES    = 18;

   // One file's verdict, in the order the block reports it.
   typedef struct packed {
      logic          found;
      container_type container;
      logic [31:0]   offset;
      logic [31:0]   size;
   } art_result_type;

   localparam art_result_type NO_ART = '{1'b0, CONT_NONE, 32'd0, 32'd0};

   // A directed file: bytes as hex text, a length (negative: the byte count) and,
   // where it is obvious, the verdict typed in by hand.
   typedef struct {
      string          hex;
      longint         flen;
      bit             typed;
      art_result_type want;
   } file_case_type;

   logic clock = 1'b0;
   logic reset;

   cal_req_if req_ch ();
   cal_rsp_if rsp_ch ();

   cover_art_locator #(.SCAN_LIMIT(SCAN_WINDOW)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Locator model: mirrors the block's state, one byte at a time.
   // ------------------------------------------------------------------
   logic [31:0]    byte_pos;
   logic [63:0]    recent;
   container_type  kind;
   logic [32:0]    id3_start;
   walk_state_type id3_walk;
   logic [32:0]    flac_start;
   walk_state_type flac_walk;
   bit             pict_seen;
   bit             ftyp_seen;
   bit             mp4_hit;
   logic [31:0]    hit_off;
   logic [31:0]    hit_sz;
   logic [31:0]    mp4_off;
   logic [31:0]    mp4_sz;

   art_result_type expected_art[$];
   logic [7:0]     file_bytes[$];
   int             error_count = 0;
   int             results_seen = 0;
   int             cycle_count = 0;
   bit             calm = 1'b0;

   function automatic void clear_locator();
      byte_pos   = '0;
      recent     = '0;
      kind       = CONT_NONE;
      id3_start  = ID3_FIRST_FRAME;
      id3_walk   = WALK_GO;
      flac_start = FLAC_FIRST_BLOCK;
      flac_walk  = WALK_GO;
      pict_seen  = 1'b0;
      ftyp_seen  = 1'b0;
      mp4_hit    = 1'b0;
      hit_off    = '0;
      hit_sz     = '0;
      mp4_off    = '0;
      mp4_sz     = '0;
   endfunction

   // Advance the model by one byte; on the last byte hand back the verdict and
   // start afresh. Every position sum is kept to 33 bits, as in the block.
   function automatic void locate_art(input logic [7:0] b, input logic lst,
                                      input logic [31:0] flen,
                                      output bit emitted, output art_result_type verdict);
      logic [63:0] pos, len, lim, rb, st, fs, fend, sz, data, ofs;
      logic [31:0] last4;
      logic [7:0]  hdr;
      pos   = {32'b0, byte_pos};
      len   = {32'b0, flen};
      lim   = (len < 64'(SCAN_WINDOW)) ? len : 64'(SCAN_WINDOW);
      rb    = {recent[55:0], b};
      last4 = rb[31:0];
      recent = rb;

      if (pos == 2 && rb[23:0] == TAG_ID3) kind = CONT_ID3;
      if (pos == 3 && last4 == TAG_FLAC) kind = CONT_FLAC;
      if (pos == 7 && last4 == TAG_FTYP) ftyp_seen = 1'b1;
      if (pos >= 3 && pos < lim && last4 == TAG_PICT) pict_seen = 1'b1;

      // ID3v2: a frame header has just completed
      st = {31'b0, id3_start};
      if (kind == CONT_ID3 && id3_walk == WALK_GO && pos == ((st + 64'd7) & MASK33)) begin
         if (st + {31'b0, ID3_HDR_LEN} >= lim) begin
            id3_walk = WALK_STOP;
         end else begin
            // size bytes are ORed in place, not masked to seven bits
            fs = {35'b0, rb[31:24], 21'b0} | {42'b0, rb[23:16], 14'b0} |
                 {49'b0, rb[15:8], 7'b0} | {56'b0, rb[7:0]};
            fend = (st + {31'b0, ID3_HDR_LEN} + fs) & MASK33;
            if (fs == 0 || fend > lim) begin
               id3_walk = WALK_STOP;
            end else if (rb[63:32] == TAG_APIC) begin
               id3_walk = WALK_FOUND;
               data     = st + {31'b0, ID3_HDR_LEN};
               hit_off  = data[31:0];
               hit_sz   = fs[31:0];
            end else begin
               id3_start = fend[32:0];
            end
         end
      end

      // FLAC: a metadata block header has just completed
      st = {31'b0, flac_start};
      if (kind == CONT_FLAC && flac_walk == WALK_GO && pos == ((st + 64'd3) & MASK33)) begin
         if (st + 64'd4 >= lim) begin
            flac_walk = WALK_STOP;
         end else begin
            hdr  = rb[31:24];
            sz   = {40'b0, rb[23:0]};
            data = (st + 64'd4) & MASK33;
            // the block end is held against the file length, not the window
            if (data + sz > len) begin
               flac_walk = WALK_STOP;
            end else if (hdr[6:0] == FLAC_PICTURE_TYPE) begin
               flac_walk = WALK_FOUND;
               hit_off   = data[31:0];
               hit_sz    = sz[31:0];
            end else begin
               fend       = (data + sz) & MASK33;
               flac_start = fend[32:0];
               if (hdr[7]) flac_walk = WALK_STOP;
            end
         end
      end

      // MP4: size word then type word on every 4-aligned offset
      if (ftyp_seen && !mp4_hit && pos >= 7 && pos[1:0] == 2'b11) begin
         ofs = pos - 64'd7;
         if (ofs + 64'd8 < lim && last4 == TAG_COVR) begin
            sz = {32'b0, rb[63:32]};
            // an oversized box is skipped and the scan carries on
            if (ofs + sz <= len) begin
               mp4_hit = 1'b1;
               data    = ofs + 64'd8;
               mp4_off = data[31:0];
               mp4_sz  = rb[63:32] - 32'd8;
            end
         end
      end

      if (byte_pos != 32'hFFFF_FFFF) byte_pos = byte_pos + 32'd1;

      emitted = lst;
      verdict = NO_ART;
      if (lst) begin
         if (kind == CONT_ID3 && id3_walk == WALK_FOUND)
            verdict = '{1'b1, CONT_ID3, hit_off, hit_sz};
         else if (kind == CONT_FLAC && flac_walk == WALK_FOUND && pict_seen)
            verdict = '{1'b1, CONT_FLAC, hit_off, hit_sz};
         else if (mp4_hit)
            verdict = '{1'b1, CONT_MP4, mp4_off, mp4_sz};
         clear_locator();
      end
   endfunction

   // ------------------------------------------------------------------
   // File builders
   // ------------------------------------------------------------------
   function automatic void put_byte(input logic [7:0] b);
      file_bytes.push_back(b);
   endfunction

   function automatic void put_word(input logic [31:0] w);
      put_byte(w[31:24]);
      put_byte(w[23:16]);
      put_byte(w[15:8]);
      put_byte(w[7:0]);
   endfunction

   // Lower-case hex pairs, spaces ignored.
   function automatic void load_hex(input string text);
      logic [7:0] acc;
      logic [3:0] nib;
      bit         half;
      byte        c;
      file_bytes = {};
      acc  = '0;
      half = 1'b0;
      for (int k = 0; k < text.len(); k++) begin
         c = text[k];
         if (c != " ") begin
            if (c >= "a") nib = 4'(c - "a" + 10);
            else nib = 4'(c - "0");
            acc = {acc[3:0], nib};
            if (half) file_bytes.push_back(acc);
            half = !half;
         end
      end
   endfunction

   function automatic void build_id3();
      int unsigned count, sel, n;
      put_byte(TAG_ID3[23:16]);
      put_byte(TAG_ID3[15:8]);
      put_byte(TAG_ID3[7:0]);
      repeat (7) put_byte(8'($urandom));
      count = $urandom_range(1, 3);
      for (int f = 0; f < count; f++) begin
         put_word((f == count - 1 || $urandom_range(0, 2) == 0) ? TAG_APIC : $urandom);
         sel = $urandom_range(0, 9);
         if (sel == 0) begin
            put_word($urandom);
            n = $urandom_range(0, 8);
         end else if (sel == 1) begin
            put_word(32'd0);
            n = 0;
         end else begin
            n = $urandom_range(1, 12);
            put_word(n);
         end
         put_byte(8'($urandom));
         put_byte(8'($urandom));
         repeat (n) put_byte(8'($urandom));
      end
   endfunction

   function automatic void build_flac();
      int unsigned count, sel, n;
      logic [6:0]  typ;
      logic        lastflag;
      put_word(TAG_FLAC);
      count = $urandom_range(1, 3);
      for (int f = 0; f < count; f++) begin
         sel = $urandom_range(0, 9);
         if (sel < 4) typ = FLAC_PICTURE_TYPE;
         else if (sel < 7) typ = 7'($urandom_range(0, 5));
         else if (sel == 7) typ = 7'h7F;
         else typ = 7'($urandom_range(0, 127));
         lastflag = (f == count - 1) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 5) == 0);
         n = ($urandom_range(0, 7) == 0) ? ($urandom & 32'h00FF_FFFF) : $urandom_range(0, 10);
         put_byte({lastflag, typ});
         put_byte(n[23:16]);
         put_byte(n[15:8]);
         put_byte(n[7:0]);
         if (n > 16) begin
            repeat ($urandom_range(0, 6)) put_byte(8'($urandom));
         end else if (typ == FLAC_PICTURE_TYPE && n >= 4 && $urandom_range(0, 3) != 0) begin
            put_word(TAG_PICT);
            repeat (n - 4) put_byte(8'($urandom));
         end else begin
            repeat (n) put_byte(8'($urandom));
         end
      end
      if ($urandom_range(0, 9) == 0) put_word(TAG_PICT);
   endfunction

   function automatic void build_mp4();
      int unsigned count, sel;
      logic [31:0] sz;
      put_word($urandom);
      put_word(TAG_FTYP);
      count = $urandom_range(1, 4);
      for (int f = 0; f < count; f++) begin
         // knock the next box off its 4-byte grid now and then
         if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
         sel = $urandom_range(0, 5);
         if (sel == 0) sz = $urandom;
         else if (sel == 1) sz = $urandom_range(0, 7);
         else sz = 32'(8 + 4 * $urandom_range(0, 3));
         put_word(sz);
         put_word($urandom_range(0, 1) ? TAG_COVR : $urandom);
         repeat ($urandom_range(0, 3)) put_word($urandom);
      end
   endfunction

   function automatic logic [31:0] pick_tag();
      case ($urandom_range(0, 5))
         0: pick_tag = TAG_APIC;
         1: pick_tag = TAG_COVR;
         2: pick_tag = TAG_FLAC;
         3: pick_tag = TAG_FTYP;
         4: pick_tag = TAG_PICT;
         default: pick_tag = {TAG_ID3, 8'($urandom)};
      endcase
   endfunction

   function automatic void build_noise();
      file_bytes = {};
      if ($urandom_range(0, 2) == 0) begin
         repeat ($urandom_range(0, 2)) put_byte(8'($urandom));
         put_word(pick_tag());
      end
      repeat ($urandom_range(1, 24)) put_byte(8'($urandom));
   endfunction

   function automatic void build_random_file();
      int unsigned sel, cut;
      file_bytes = {};
      sel = $urandom_range(0, 99);
      if (sel < 28) build_id3();
      else if (sel < 53) build_flac();
      else if (sel < 78) build_mp4();
      else build_noise();
      // break a share of the files
      if ($urandom_range(0, 9) == 0)
         file_bytes[$urandom_range(0, file_bytes.size() - 1)] ^= 8'($urandom_range(1, 255));
      if ($urandom_range(0, 99) < 12) begin
         cut = $urandom_range(0, file_bytes.size() - 1);
         repeat (cut) void'(file_bytes.pop_back());
      end
      if ($urandom_range(0, 99) < 15) repeat ($urandom_range(1, 4)) put_byte(8'($urandom));
   endfunction

   function automatic logic [31:0] pick_length(input int unsigned n);
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: pick_length = n;
         5, 6: pick_length = n + $urandom_range(1, 64);
         7: pick_length = $urandom_range(0, n - 1);
         8: pick_length = $urandom_range(0, 1) ? 32'hFFFF_FFFF : SCAN_WINDOW;
         default: pick_length = $urandom;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Byte stream driver
   // ------------------------------------------------------------------
   task automatic send_byte(input logic [7:0] b, input logic lst, input logic [31:0] flen,
                            input bit typed, input art_result_type want);
      bit             emitted;
      art_result_type verdict;
      // drop valid now and then, unless in the calm stretch
      while (!calm && $urandom_range(0, 99) < 6) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= b;
      req_ch.last_byte   <= lst;
      req_ch.file_length <= flen;
      do @(posedge clock); while (!req_ch.ready);
      locate_art(b, lst, flen, emitted, verdict);
      if (emitted) expected_art.push_back(typed ? want : verdict);
   endtask

   // Stream file_bytes; the length switches to len_b from byte switch_at on.
   task automatic send_file(input logic [31:0] len_a, input logic [31:0] len_b,
                            input int switch_at, input bit typed, input art_result_type want);
      for (int k = 0; k < file_bytes.size(); k++)
         send_byte(file_bytes[k], k == file_bytes.size() - 1,
                   (k >= switch_at) ? len_b : len_a, typed, want);
   endtask

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR result %0d: %s got %0h want %0h", results_seen, what, got, want);
      error_count++;
   endtask

   // ------------------------------------------------------------------
   // Result side: check against the oldest expectation, stall at random.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : result_check
      art_result_type want;
      if (!reset) begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_art.size() == 0) begin
               report_mismatch("unexpected result, offset", rsp_ch.image_offset, 32'd0);
            end else begin
               want = expected_art.pop_front();
               if (rsp_ch.found !== want.found)
                  report_mismatch("found", 32'(rsp_ch.found), 32'(want.found));
               if (rsp_ch.container !== want.container)
                  report_mismatch("container", 32'(rsp_ch.container), 32'(want.container));
               if (rsp_ch.image_offset !== want.offset)
                  report_mismatch("image_offset", rsp_ch.image_offset, want.offset);
               if (rsp_ch.image_size !== want.size)
                  report_mismatch("image_size", rsp_ch.image_size, want.size);
            end
            results_seen++;
         end
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 6);
      end
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cover_art_locator: mismatch");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   file_case_type cases[NUM_CASES];

   initial begin : stimulus
      int          random_bytes;
      int          files_done;
      int          switch_at;
      logic [31:0] len_a, len_b;

      reset              = 1'b1;
      req_ch.valid       = 1'b0;
      req_ch.data_byte   = '0;
      req_ch.last_byte   = 1'b0;
      req_ch.file_length = '0;
      rsp_ch.ready       = 1'b0;
      clear_locator();

      // single byte, nothing to find
      cases[0]  = '{"00", -1, 1'b1, NO_ART};
      // ID3 with an APIC first frame
      cases[1]  = '{"494433 00000000000000 41504943 00000004 0000 deadbeef", -1, 1'b1,
                    '{1'b1, CONT_ID3, 32'd20, 32'd4}};
      // ORed size bytes, full-scale length: 2<<7 | 0x81
      cases[2]  = '{"494433 04000000000000 41504943 00000281 0000", 64'hFFFF_FFFF, 1'b1,
                    '{1'b1, CONT_ID3, 32'd20, 32'd385}};
      // skip one frame, then APIC
      cases[3]  = '{{"494433 00000000000000 54495432 00000002 0000 ffff ",
                     "41504943 00000003 0000 010203"}, -1, 1'b1,
                    '{1'b1, CONT_ID3, 32'd32, 32'd3}};
      // zero frame size stops the ID3 walker
      cases[4]  = '{"494433 00000000000000 41504943 00000000 0000", 64'hFFFF_FFFF,
                    1'b1, NO_ART};
      // file ends before the frame header is whole
      cases[5]  = '{"494433 00000000000000 41504943", 100, 1'b1, NO_ART};
      // zero length shuts every window
      cases[6]  = '{"494433 00000000000000 41504943 00000004 0000 deadbeef", 0, 1'b1, NO_ART};
      // FLAC picture as the first and last block
      cases[7]  = '{"664c6143 86000004 50494354", -1, 1'b1,
                    '{1'b1, CONT_FLAC, 32'd8, 32'd4}};
      // FLAC picture as the second block
      cases[8]  = '{"664c6143 04000002 abcd 06000004 50494354", -1, 1'b1,
                    '{1'b1, CONT_FLAC, 32'd14, 32'd4}};
      // picture block but no PICT in the window
      cases[9]  = '{"664c6143 06000002 0000", -1, 1'b1, NO_ART};
      // block that runs past the file
      cases[10] = '{"664c6143 00000010 50494354 06000000", -1, 1'b1, NO_ART};
      // last-block flag ahead of the picture
      cases[11] = '{"664c6143 80000000 06000004 50494354", -1, 1'b1, NO_ART};
      // MP4 covr box
      cases[12] = '{"00000018 66747970 00000000 00000000 0000000c 636f7672 11223344", -1,
                    1'b1, '{1'b1, CONT_MP4, 32'd24, 32'd4}};
      // covr size under 8 wraps the image size
      cases[13] = '{"00000000 66747970 00000004 636f7672 ffffffff", -1, 1'b1,
                    '{1'b1, CONT_MP4, 32'd16, 32'hFFFF_FFFC}};
      // oversized covr skipped, the next one taken
      cases[14] = '{"00000000 66747970 00000100 636f7672 00000008 636f7672", 64, 1'b1,
                    '{1'b1, CONT_MP4, 32'd24, 32'd0}};
      // ID3 outranks a covr in the same file
      cases[15] = '{"494433 00 66747970 0000 41504943 00000008 0000 00000008 636f7672", 40,
                    1'b1, '{1'b1, CONT_ID3, 32'd20, 32'd8}};
      // magic one byte late
      cases[16] = '{"ff 494433 ff", -1, 1'b1, NO_ART};
      // FLAC with a type 0x7f block, left to the model
      cases[17] = '{"664c6143 7f000001 ff 86000004 50494354", 64'hFFFF_FFFF, 1'b0, NO_ART};

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed files.
      for (int k = 0; k < NUM_CASES; k++) begin
         load_hex(cases[k].hex);
         len_a = (cases[k].flen < 0) ? file_bytes.size() : cases[k].flen[31:0];
         send_file(len_a, len_a, file_bytes.size(), cases[k].typed, cases[k].want);
      end

      // Random files: mostly well-formed containers with random content.
      random_bytes = 0;
      files_done   = 0;
      while (random_bytes < RANDOM_BYTES || files_done < MIN_FILES) begin
         calm = (files_done >= 8 && files_done < 16);
         // hold back once until the block has emptied
         if (files_done == 4) begin
            req_ch.valid <= 1'b0;
            while (expected_art.size() != 0) @(posedge clock);
         end
         build_random_file();
         len_a     = pick_length(file_bytes.size());
         len_b     = pick_length(file_bytes.size());
         switch_at = ($urandom_range(0, 19) == 0) ? $urandom_range(0, file_bytes.size() - 1)
                                                  : file_bytes.size();
         send_file(len_a, len_b, switch_at, 1'b0, NO_ART);
         random_bytes += file_bytes.size();
         files_done++;
      end
      calm = 1'b0;

      // Drain: wait for the last verdicts, then let the bench idle before the summary.
      req_ch.valid <= 1'b0;
      while (expected_art.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("cover_art_locator: match");
      end else begin
         $display("cover_art_locator: mismatch");
      end
      $finish;
   end

endmodule
